@@ sv/flash_page_merge_writer_unit_defines.svh @@
// assertion macros shared by the flash page merge writer files
`ifndef FLASH_PAGE_MERGE_WRITER_UNIT_DEFINES_SVH
`define FLASH_PAGE_MERGE_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define FPMW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flash page merge writer: assertion failed");

// next-cycle implication, disabled in reset
`define FPMW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flash page merge writer: assertion failed");

`else

`define FPMW_ASSERT_IMPL(label, clk, rst, ante, cons)

`define FPMW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/fpmw_pkg.sv @@
// shared constants, codes and job type of the flash page merge writer
package fpmw_pkg;

   // default page size in words
   localparam int unsigned PAGE_WORDS_DEFAULT = 64;

   // job queue depth between front and back (power of two)
   localparam int unsigned QUEUE_DEPTH = 4;

   // request command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // result operation codes
   localparam logic [2:0] OP_FILL   = 3'd0;
   localparam logic [2:0] OP_KEEP   = 3'd1;
   localparam logic [2:0] OP_ERASE  = 3'd2;
   localparam logic [2:0] OP_WRITE  = 3'd3;
   localparam logic [2:0] OP_RWW    = 3'd4;
   localparam logic [2:0] OP_REJECT = 3'd5;

   // job kinds handed from front to back
   localparam logic [1:0] JOB_REJECT = 2'd0;
   localparam logic [1:0] JOB_LEAD   = 2'd1;
   localparam logic [1:0] JOB_DATA   = 2'd2;

   // one classified job
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] word_addr;   // fill address for data jobs
      logic [15:0] base_addr;   // page base (lead keep start, erase, write)
      logic [7:0]  count;       // keep count (lead offset or trailing rest)
      logic [15:0] fill_word;
      logic        close;       // page is finished by this data word
      logic        done;        // last word of the whole write
   } job_type;

endpackage

@@ sv/fpmw_front.sv @@
// front end: accepts beats, tracks write progress and classifies them into jobs
module fpmw_front #(
   parameter int unsigned PAGE_WORDS = fpmw_pkg::PAGE_WORDS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_command,
   input  logic [15:0]      req_start_word_address,
   input  logic [15:0]      req_byte_size,
   input  logic [15:0]      req_data_word,
   output logic             push,
   output fpmw_pkg::job_type push_job,
   input  logic             queue_full
);
   import fpmw_pkg::*;

   // reciprocal for the page offset: a_q_ff is the quotient or one below it
   localparam int unsigned RECIP_SHIFT = 24;
   localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / PAGE_WORDS;
   localparam logic [15:0] PAGE_W16    = 16'(PAGE_WORDS);
   localparam logic [7:0]  PAGE_LAST   = 8'(PAGE_WORDS - 1);

   // stage a registers
   logic        a_valid_ff, a_valid_in;
   logic        a_cmd_ff;
   logic [15:0] a_addr_ff, a_size_ff, a_data_ff, a_q_ff;

   // write progress state
   logic        active_ff, active_in;
   logic [14:0] words_left_ff, words_left_in;
   logic [15:0] next_addr_ff, next_addr_in;
   logic [7:0]  off_ff, off_in;

   logic        req_accept, b_moves;
   logic [39:0] prod;
   logic [15:0] qp, rem_raw, rem_fix;
   logic [7:0]  start_off;
   logic        size_bad, last_word, page_end;
   logic [15:0] tail, lead_base, page_base;
   logic [7:0]  span, rest;

   assign req_stall  = a_valid_ff && queue_full;
   assign req_accept = req_valid && !req_stall;
   assign b_moves    = a_valid_ff && !queue_full;

   // quotient estimate for the start address, registered with the beat
   assign prod = {24'd0, req_start_word_address} * 40'(RECIP);

   assign a_valid_in = req_accept ? 1'b1 : (b_moves ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_cmd_ff  <= req_command;
         a_addr_ff <= req_start_word_address;
         a_size_ff <= req_byte_size;
         a_data_ff <= req_data_word;
         a_q_ff    <= prod[39:24];
      end
   end

   // page offset of the start address with one correction step
   assign qp        = a_q_ff * PAGE_W16;
   assign rem_raw   = a_addr_ff - qp;
   assign rem_fix   = (rem_raw >= PAGE_W16) ? (rem_raw - PAGE_W16) : rem_raw;
   assign start_off = rem_fix[7:0];
   assign size_bad  = (a_size_ff == 16'd0) || a_size_ff[0];
   assign lead_base = a_addr_ff - {8'd0, start_off};

   // data word classification
   assign last_word = (words_left_ff == 15'd1);
   assign page_end  = (off_ff == PAGE_LAST) || (next_addr_ff == 16'hFFFF);
   assign tail      = ~next_addr_ff;
   assign span      = PAGE_LAST - off_ff;
   assign rest      = (tail < {8'd0, span}) ? tail[7:0] : span;
   assign page_base = next_addr_ff - {8'd0, off_ff};

   // state update and job build
   always_comb begin
      active_in     = active_ff;
      words_left_in = words_left_ff;
      next_addr_in  = next_addr_ff;
      off_in        = off_ff;
      push          = 1'b0;
      push_job      = '0;
      if (b_moves) begin
         if (a_cmd_ff == CMD_START) begin
            if (size_bad) begin
               active_in      = 1'b0;
               words_left_in  = 15'd0;
               push           = 1'b1;
               push_job.kind  = JOB_REJECT;
            end else begin
               active_in          = 1'b1;
               words_left_in      = a_size_ff[15:1];
               next_addr_in       = a_addr_ff;
               off_in             = start_off;
               push               = (start_off != 8'd0);
               push_job.kind      = JOB_LEAD;
               push_job.base_addr = lead_base;
               push_job.count     = start_off;
            end
         end else if (active_ff) begin
            push               = 1'b1;
            push_job.kind      = JOB_DATA;
            push_job.word_addr = next_addr_ff;
            push_job.base_addr = page_base;
            push_job.count     = rest;
            push_job.fill_word = a_data_ff;
            push_job.close     = last_word || page_end;
            push_job.done      = last_word;
            words_left_in      = words_left_ff - 15'd1;
            next_addr_in       = next_addr_ff + 16'd1;
            off_in             = page_end ? 8'd0 : (off_ff + 8'd1);
            active_in          = !last_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         words_left_ff <= 15'd0;
         next_addr_ff  <= 16'd0;
         off_ff        <= 8'd0;
      end else begin
         active_ff     <= active_in;
         words_left_ff <= words_left_in;
         next_addr_ff  <= next_addr_in;
         off_ff        <= off_in;
      end
   end

endmodule

@@ sv/fpmw_queue.sv @@
// short job queue between front end and back end
`include "flash_page_merge_writer_unit_defines.svh"

module fpmw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fpmw_pkg::job_type push_job,
   input  logic              pop,
   output fpmw_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);
   import fpmw_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = PTR_W + 1;

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_job = slot_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // the front end only pushes into a free slot, the back end only pops a held job
   `FPMW_ASSERT_IMPL(a_queue_no_overflow, clock, reset, push, !full || pop)
   `FPMW_ASSERT_IMPL(a_queue_no_underflow, clock, reset, pop, !empty)

endmodule

@@ sv/fpmw_back.sv @@
// back end: expands each job into flash operations on the result channel
`include "flash_page_merge_writer_unit_defines.svh"

module fpmw_back (
   input  logic              clock,
   input  logic              reset,
   input  fpmw_pkg::job_type head_job,
   input  logic              queue_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_operation,
   output logic [16:0]       rsp_byte_address,
   output logic [7:0]        rsp_keep_count,
   output logic [15:0]       rsp_fill_word,
   output logic              rsp_last
);
   import fpmw_pkg::*;

   // current job and its step
   job_type     cur_ff;
   logic        cur_valid_ff, cur_valid_in;
   logic [2:0]  step_ff, step_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  op_ff;
   logic [16:0] addr_ff;
   logic [7:0]  count_ff;
   logic [15:0] word_ff;
   logic        last_ff;

   logic        out_load;
   logic [2:0]  op_c, next_step;
   logic [15:0] waddr_c;
   logic [7:0]  count_c;
   logic [15:0] word_c;
   logic        last_c;

   assign out_load = cur_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop      = !queue_empty && (!cur_valid_ff || (out_load && last_c));

   // operation for the current step
   always_comb begin
      op_c      = OP_REJECT;
      waddr_c   = 16'd0;
      count_c   = 8'd0;
      word_c    = 16'd0;
      last_c    = 1'b1;
      next_step = OP_FILL;
      case (cur_ff.kind)
         JOB_REJECT: begin
            op_c = OP_REJECT;
         end
         JOB_LEAD: begin
            op_c    = OP_KEEP;
            waddr_c = cur_ff.base_addr;
            count_c = cur_ff.count;
         end
         JOB_DATA: begin
            case (step_ff)
               OP_FILL: begin
                  op_c      = OP_FILL;
                  waddr_c   = cur_ff.word_addr;
                  word_c    = cur_ff.fill_word;
                  last_c    = !cur_ff.close;
                  next_step = (cur_ff.count != 8'd0) ? OP_KEEP : OP_ERASE;
               end
               OP_KEEP: begin
                  op_c      = OP_KEEP;
                  waddr_c   = cur_ff.word_addr + 16'd1;
                  count_c   = cur_ff.count;
                  last_c    = 1'b0;
                  next_step = OP_ERASE;
               end
               OP_ERASE: begin
                  op_c      = OP_ERASE;
                  waddr_c   = cur_ff.base_addr;
                  last_c    = 1'b0;
                  next_step = OP_WRITE;
               end
               OP_WRITE: begin
                  op_c      = OP_WRITE;
                  waddr_c   = cur_ff.base_addr;
                  last_c    = !cur_ff.done;
                  next_step = OP_RWW;
               end
               default: begin
                  op_c = OP_RWW;
               end
            endcase
         end
         default: begin
            op_c = OP_REJECT;
         end
      endcase
   end

   // job sequencing
   always_comb begin
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         step_in      = OP_FILL;
      end else if (out_load) begin
         cur_valid_in = !last_c;
         step_in      = next_step;
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= OP_FILL;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_job;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (out_load) begin
         op_ff    <= op_c;
         addr_ff  <= {waddr_c, 1'b0};
         count_ff <= count_c;
         word_ff  <= word_c;
         last_ff  <= last_c;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_operation    = op_ff;
   assign rsp_byte_address = addr_ff;
   assign rsp_keep_count   = count_ff;
   assign rsp_fill_word    = word_ff;
   assign rsp_last         = last_ff;

   // a job that is not finished stays loaded, enable rww always ends its job
   `FPMW_ASSERT_NEXT(a_back_job_held, clock, reset, out_load && !last_c, cur_valid_ff)
   `FPMW_ASSERT_IMPL(a_back_rww_last, clock, reset, out_load && op_c == OP_RWW, last_c)

endmodule

@@ sv/flash_page_merge_writer_unit.sv @@
// top level of the flash page merge writer
//
//  channel | direction | beat                                         | handshake
//  req     | in        | command, start address, byte size, data word | req_valid / req_stall
//  rsp     | out       | operation, byte address, keep count, word    | rsp_valid / rsp_stall
//
// a beat leaves the front stage when the job queue has room; its first result
// passes the front stage, the job queue, the current job and the result register.
// a data word that does not close a page gives one result beat; one that closes
// a page gives up to five, one per cycle unless rsp_stall holds them, which sets the rate.
// a start beat gives one result beat or none; a data word while idle gives none.
// reset is synchronous and clears the write progress, the queue and all valids.
// the request side stalls when the four-entry job queue is full and the front
// stage holds a beat.
module flash_page_merge_writer_unit #(
   parameter int unsigned PAGE_WORDS = fpmw_pkg::PAGE_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [15:0] req_start_word_address,
   input  logic [15:0] req_byte_size,
   input  logic [15:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_operation,
   output logic [16:0] rsp_byte_address,
   output logic [7:0]  rsp_keep_count,
   output logic [15:0] rsp_fill_word,
   output logic        rsp_last
);
   import fpmw_pkg::*;

   logic    push, pop, queue_full, queue_empty;
   job_type push_job, head_job;

   // classify incoming beats
   fpmw_front #(
      .PAGE_WORDS(PAGE_WORDS)
   ) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_start_word_address (req_start_word_address),
      .req_byte_size          (req_byte_size),
      .req_data_word          (req_data_word),
      .push                   (push),
      .push_job               (push_job),
      .queue_full             (queue_full)
   );

   // decouple front and back
   fpmw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // expand jobs into flash operations
   fpmw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_job         (head_job),
      .queue_empty      (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_operation    (rsp_operation),
      .rsp_byte_address (rsp_byte_address),
      .rsp_keep_count   (rsp_keep_count),
      .rsp_fill_word    (rsp_fill_word),
      .rsp_last         (rsp_last)
   );

endmodule

@@ test/tb_flash_page_merge_writer_unit.sv @@
// self-checking testbench of the flash page merge writer: directed table, then random writes
module tb_flash_page_merge_writer_unit;
   import fpmw_pkg::*;

   localparam int unsigned PAGE_WORDS = PAGE_WORDS_DEFAULT;
   localparam int unsigned PAGES      = 65536 / PAGE_WORDS;
   localparam int          HOLD_CYCLES = 60;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          PHASE_ITEMS = 55;
   localparam int          MAX_REPORTS = 10;

   // one flash page-buffer operation as seen on the result port
   typedef struct packed {
      logic [2:0]  op;
      logic [16:0] byte_addr;
      logic [7:0]  keep;
      logic [15:0] fill;
      logic        last;
   } flash_op_type;

   // one directed beat, with an optional typed-in result
   typedef struct packed {
      logic      cmd;
      logic [15:0] addr;
      logic [15:0] size;
      logic [15:0] data;
      logic        typed;
      flash_op_type want;
   } stim_row_type;

   localparam flash_op_type UNTYPED = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_START;
   logic [15:0] req_start_word_address = '0;
   logic [15:0] req_byte_size = '0;
   logic [15:0] req_data_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_operation;
   logic [16:0] rsp_byte_address;
   logic [7:0]  rsp_keep_count;
   logic [15:0] rsp_fill_word;
   logic        rsp_last;

   // predictor copy of the write progress
   logic        wr_active = 1'b0;
   logic [14:0] wr_words_left = '0;
   logic [15:0] wr_next_addr = '0;

   flash_op_type step_ops[$];
   flash_op_type expected_ops[$];
   int          mismatch_count = 0;
   int          items_taken = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_req = 1'b0;
   int          hold_left = 0;

   // directed beats: extremes, rejects, page crossing, address wrap, restart while active
   stim_row_type directed_rows [0:21] = '{
      '{CMD_DATA,  16'h0000, 16'h0000, 16'hFFFF, 1'b0, UNTYPED},
      '{CMD_START, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{OP_REJECT, 17'h0, 8'd0, 16'h0, 1'b1}},
      '{CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{OP_REJECT, 17'h0, 8'd0, 16'h0, 1'b1}},
      '{CMD_START, 16'h0005, 16'h0004, 16'h0000, 1'b1, '{OP_KEEP, 17'h0, 8'd5, 16'h0, 1'b1}},
      '{CMD_DATA,  16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
        '{OP_FILL, 17'h0000A, 8'd0, 16'h0000, 1'b1}},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'hFFFF, 1'b0, UNTYPED},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'h1234, 1'b0, UNTYPED},
      '{CMD_START, 16'h003E, 16'h0006, 16'h0000, 1'b0, UNTYPED},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'hA5A5, 1'b0, UNTYPED},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'h5A5A, 1'b0, UNTYPED},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'h0F0F, 1'b0, UNTYPED},
      '{CMD_START, 16'hFFFF, 16'h0004, 16'h0000, 1'b1,
        '{OP_KEEP, 17'h1FF80, 8'd63, 16'h0, 1'b1}},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'h8001, 1'b0, UNTYPED},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'h7FFE, 1'b0, UNTYPED},
      '{CMD_START, 16'h0100, 16'h0100, 16'h0000, 1'b0, UNTYPED},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'h3C3C, 1'b0, UNTYPED},
      '{CMD_START, 16'h0040, 16'h0002, 16'h0000, 1'b0, UNTYPED},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'hC3C3, 1'b0, UNTYPED},
      '{CMD_START, 16'hFFFF, 16'hFFFE, 16'h0000, 1'b1,
        '{OP_KEEP, 17'h1FF80, 8'd63, 16'h0, 1'b1}},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'h1111, 1'b0, UNTYPED},
      '{CMD_START, 16'h0000, 16'h0002, 16'h0000, 1'b0, UNTYPED},
      '{CMD_DATA,  16'h0000, 16'h0000, 16'hFFFF, 1'b0, UNTYPED}
   };

   flash_page_merge_writer_unit #(
      .PAGE_WORDS(PAGE_WORDS)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_start_word_address(req_start_word_address),
      .req_byte_size         (req_byte_size),
      .req_data_word         (req_data_word),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_operation         (rsp_operation),
      .rsp_byte_address      (rsp_byte_address),
      .rsp_keep_count        (rsp_keep_count),
      .rsp_fill_word         (rsp_fill_word),
      .rsp_last              (rsp_last)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #1000000;
      $display("tb_flash_page_merge_writer_unit failed");
      $finish;
   end

   function automatic void add_op(logic [2:0] op, int unsigned word_addr, int unsigned keep,
                                  logic [15:0] fill);
      flash_op_type o;
      o.op        = op;
      o.byte_addr = 17'(word_addr << 1);
      o.keep      = 8'(keep);
      o.fill      = fill;
      o.last      = 1'b0;
      step_ops.push_back(o);
   endfunction

   // works out the page-buffer operations of one beat; returns 0 for an ignored data word
   function automatic bit plan_flash_ops(logic cmd, logic [15:0] addr, logic [15:0] size,
                                         logic [15:0] data);
      int unsigned a, base, lim, off;
      bit          done;
      step_ops.delete();
      if (cmd == CMD_START) begin
         wr_active     = 1'b0;
         wr_words_left = '0;
         if (size == 16'd0 || size[0]) begin
            add_op(OP_REJECT, 0, 0, 16'h0);
         end else begin
            off           = addr % PAGE_WORDS;
            wr_active     = 1'b1;
            wr_words_left = size[15:1];
            wr_next_addr  = addr;
            if (off != 0) add_op(OP_KEEP, addr - off, off, 16'h0);
         end
      end else begin
         if (!wr_active) return 1'b0;
         a = wr_next_addr;
         add_op(OP_FILL, a, 0, data);
         wr_words_left = wr_words_left - 15'd1;
         done = (wr_words_left == 15'd0);
         base = a - a % PAGE_WORDS;
         lim  = base + PAGE_WORDS;
         if (lim > 32'h10000) lim = 32'h10000;
         // close the page: trailing keep, erase, write, and rww after the last word
         if (done || a + 1 >= lim) begin
            if (lim - (a + 1) != 0) add_op(OP_KEEP, a + 1, lim - (a + 1), 16'h0);
            add_op(OP_ERASE, base, 0, 16'h0);
            add_op(OP_WRITE, base, 0, 16'h0);
            if (done) add_op(OP_RWW, 0, 0, 16'h0);
         end
         wr_next_addr = 16'(a + 1);
         if (done) wr_active = 1'b0;
      end
      if (step_ops.size() != 0) step_ops[step_ops.size() - 1].last = 1'b1;
      return 1'b1;
   endfunction

   // offers one beat after random idle cycles and waits until it is taken
   task automatic send_beat(logic cmd, logic [15:0] addr, logic [15:0] size, logic [15:0] data,
                            logic typed = 1'b0, flash_op_type want = UNTYPED);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      if (plan_flash_ops(cmd, addr, size, data)) items_taken++;
      if (typed) begin
         expected_ops.push_back(want);
      end else begin
         foreach (step_ops[i]) expected_ops.push_back(step_ops[i]);
      end
      req_valid              <= 1'b1;
      req_command            <= cmd;
      req_start_word_address <= addr;
      req_byte_size          <= size;
      req_data_word          <= data;
      do @(posedge clock); while (req_stall);
   endtask

   // sender pauses until every expected beat has come back
   task automatic wait_results_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_ops.size() != 0) @(posedge clock);
   endtask

   // one random write sequence, mostly well formed
   task automatic run_random_sequence();
      int          kind, n;
      logic [15:0] a, sz;
      kind = $urandom_range(0, 9);
      case (kind)
         0: begin
            // stray data word
            send_beat(CMD_DATA, 16'($urandom), 16'($urandom), 16'($urandom));
         end
         1: begin
            // zero or odd byte count
            sz = 16'($urandom);
            if ($urandom_range(0, 3) == 0) sz = 16'd0;
            else sz[0] = 1'b1;
            send_beat(CMD_START, 16'($urandom), sz, 16'($urandom));
         end
         2: begin
            // large even count, abandoned by the next start
            sz = 16'($urandom);
            sz[0] = 1'b0;
            if (sz < 16'd20) sz = 16'd20;
            send_beat(CMD_START, 16'($urandom), sz, 16'($urandom));
            n = $urandom_range(0, 4);
            repeat (n) send_beat(CMD_DATA, 16'($urandom), 16'($urandom), 16'($urandom));
         end
         default: begin
            // complete write from a random address, a page start, near a page end or the top
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 6);
            case ($urandom_range(0, 3))
               0: a = 16'($urandom);
               1: a = 16'($urandom_range(0, PAGES - 1) * PAGE_WORDS + PAGE_WORDS
                          - $urandom_range(1, 3));
               2: a = 16'hFFFF - 16'($urandom_range(0, 3));
               default: a = 16'($urandom_range(0, PAGES - 1) * PAGE_WORDS);
            endcase
            send_beat(CMD_START, a, 16'(n * 2), 16'($urandom));
            repeat (n) send_beat(CMD_DATA, 16'($urandom), 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 4) == 0)
               send_beat(CMD_DATA, 16'($urandom), 16'($urandom), 16'($urandom));
         end
      endcase
   endtask

   // receiver stall, with a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // result check against the oldest expected beat
   always @(posedge clock) begin
      flash_op_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_operation, rsp_byte_address, rsp_keep_count, rsp_fill_word, rsp_last};
         if (expected_ops.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat: op %0d addr %h keep %0d fill %h last %b",
                        got.op, got.byte_addr, got.keep, got.fill, got.last);
         end else begin
            want = expected_ops.pop_front();
            if (got.op !== want.op || got.byte_addr !== want.byte_addr ||
                got.keep !== want.keep || got.fill !== want.fill || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result mismatch: expected op %0d addr %h keep %0d fill %h last %b, %s",
                           want.op, want.byte_addr, want.keep, want.fill, want.last,
                           $sformatf("got op %0d addr %h keep %0d fill %h last %b",
                                     got.op, got.byte_addr, got.keep, got.fill, got.last));
            end
         end
      end
   end

   // stimulus
   initial begin
      int first;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles 30 percent, receiver 55 percent
      send_idle_pct = 30;
      recv_idle_pct = 55;
      foreach (directed_rows[i])
         send_beat(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].size,
                   directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
      wait_results_done();

      // long receiver hold-off while beats keep coming, so the job queue fills
      hold_req = 1'b1;
      first = items_taken;
      while (items_taken - first < PHASE_ITEMS) run_random_sequence();
      wait_results_done();

      // roles swapped
      send_idle_pct = 55;
      recv_idle_pct = 30;
      first = items_taken;
      while (items_taken - first < PHASE_ITEMS) run_random_sequence();
      wait_results_done();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      first = items_taken;
      while (items_taken - first < PHASE_ITEMS) run_random_sequence();
      wait_results_done();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_ops.size() == 0) begin
         $display("tb_flash_page_merge_writer_unit passed");
      end else begin
         $display("tb_flash_page_merge_writer_unit failed");
      end
      $finish;
   end

endmodule
